[rtl/gcd_pkg.sv]
// ----------------------------------------------------------------------------
// gcd_pkg
// shared constants and the cordic arctangent table for the great-circle core
// ----------------------------------------------------------------------------
`default_nettype none

package gcd_pkg;

    localparam int CW                = 34;
    localparam int CORDIC_ITERATIONS = 24;
    localparam int SQ_STEPS          = 31;
    localparam int SQ_IN_W           = 2 * SQ_STEPS - 1;
    localparam int SQ_W              = 2 * SQ_STEPS;
    localparam int LANES             = 4;
    localparam int ADDR_W            = 3;

    localparam logic        REG_RADIUS = 1'b0;

    localparam logic [32:0] PI_Q30      = 33'd3373259426;
    localparam logic [33:0] TWO_PI_Q30  = 34'd6746518852;
    localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic [21:0] DIV_C     = 22'd3515625;
    localparam logic [31:0] DIV_RECIP = 32'((64'd1 << 53) / 64'd3515625);
    localparam logic [31:0] BIAS_HALF = 32'd1800000000;
    localparam logic [31:0] BIAS_LAT  = 32'd900000000;

    localparam logic [30:0] ONE_Q30   = 31'd1073741824;
    localparam logic [32:0] DIST_MAX  = 33'd5270000000;
    localparam logic [23:0] RADIUS_RESET = 24'd6376500;
    localparam logic [30:0] RADIUS100_RESET = 31'd637650000;

    function automatic logic signed [CW-1:0] atan_step(input int i);
        logic signed [CW-1:0] v;
        case (i)
            0:  v = 34'sd843314857;
            1:  v = 34'sd497837829;
            2:  v = 34'sd263043837;
            3:  v = 34'sd133525159;
            4:  v = 34'sd67021687;
            5:  v = 34'sd33543516;
            6:  v = 34'sd16775851;
            7:  v = 34'sd8388437;
            8:  v = 34'sd4194283;
            9:  v = 34'sd2097149;
            10: v = 34'sd1048576;
            default: begin
                if (i <= 30) begin
                    v = CW'(1) << (30 - i);
                end else begin
                    v = '0;
                end
            end
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[rtl/great_circle_distance_core.sv]
// ----------------------------------------------------------------------------
// great_circle_distance_core
// haversine great-circle distance between two points, in centimetres
// ----------------------------------------------------------------------------
// input channel i_valid/o_ready carries one point pair per item (latitudes and
// longitudes in 1e-7 degree); output channel o_valid/i_ready returns the
// distance and a saturation flag, one result item per input item, in order.
// the sphere radius in metres sits at byte address 0 of the apb-style port.
// the datapath is one pipeline with a common advance enable: angle conversion
// (6 stages), four parallel sin/cos cordics (CORDIC_ITERATIONS stages), the
// haversine products (3 stages), two square roots (31 stages), the atan2
// cordic (CORDIC_ITERATIONS stages) and the radius scaling (2 stages).
// throughput is one item per cycle while the receiver does not stall.
// reset clears all valid bits and loads the default radius of 6376500 m.
// when the receiver stalls with a result waiting, the whole pipeline holds
// and o_ready drops; no item is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module great_circle_distance_core #(
    parameter int CORDIC_ITERATIONS = gcd_pkg::CORDIC_ITERATIONS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic signed [30:0]            i_base_latitude,
    input  wire logic signed [31:0]            i_base_longitude,
    input  wire logic signed [30:0]            i_other_latitude,
    input  wire logic signed [31:0]            i_other_longitude,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [32:0]                        o_distance_cm,
    output logic                               o_saturated,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [gcd_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    localparam int CW    = gcd_pkg::CW;
    localparam int NL    = gcd_pkg::LANES;
    localparam int ITER  = CORDIC_ITERATIONS;
    localparam int LAT   = 42 + 2 * ITER;
    localparam int SQS   = gcd_pkg::SQ_STEPS;

    // configuration
    logic [23:0] r_radius;
    logic [30:0] r_radius100;
    logic        w_wr;

    assign w_wr   = psel & penable & pwrite & (paddr[gcd_pkg::ADDR_W-1] == gcd_pkg::REG_RADIUS);
    assign pready = 1'b1;
    assign prdata = (paddr[gcd_pkg::ADDR_W-1] == gcd_pkg::REG_RADIUS) ? {8'd0, r_radius} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius    <= gcd_pkg::RADIUS_RESET;
            r_radius100 <= gcd_pkg::RADIUS100_RESET;
        end else if (w_wr) begin
            r_radius    <= pwdata[23:0];
            r_radius100 <= 31'(pwdata[23:0]) * 31'd100;
        end
    end

    // pipeline control
    logic           w_en;
    logic [LAT-1:0] r_vld;

    assign w_en    = ~r_vld[LAT-1] | i_ready;
    assign o_ready = w_en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // lanes: half lat diff, half lon diff, base lat, other lat
    logic signed [31:0] w_dlat;
    logic signed [32:0] w_dlon;
    logic [31:0]        n_m    [NL];
    logic [31:0]        r_m    [NL];
    logic [53:0]        r_nh   [NL];
    logic [31:0]        r_qe   [NL];
    logic [25:0]        r_nlo  [NL];
    logic [31:0]        r_qe2  [NL];
    logic [25:0]        r_rem  [NL];
    logic [31:0]        r_q    [NL];
    logic [31:0]        r_z0   [NL];
    logic [1:0]         r_fneg;

    assign w_dlat = {i_other_latitude[30], i_other_latitude}
                  - {i_base_latitude[30], i_base_latitude};
    assign w_dlon = {i_other_longitude[31], i_other_longitude}
                  - {i_base_longitude[31], i_base_longitude};

    always_comb begin
        n_m[0] = w_dlat[31] ? (~w_dlat + 32'd1) : w_dlat;
        n_m[1] = w_dlon[32] ? 32'(~w_dlon + 33'd1) : w_dlon[31:0];
        n_m[2] = i_base_latitude[30]
               ? (~{i_base_latitude[30], i_base_latitude} + 32'd1)
               : {i_base_latitude[30], i_base_latitude};
        n_m[3] = i_other_latitude[30]
               ? (~{i_other_latitude[30], i_other_latitude} + 32'd1)
               : {i_other_latitude[30], i_other_latitude};
    end

    for (genvar l = 0; l < NL; l++) begin : g_conv
        logic [63:0] w_n;
        logic [63:0] w_p3;
        logic [53:0] w_p4;
        logic [25:0] w_rem;
        logic [31:0] w_cnt;
        logic [31:0] w_m1;
        logic        w_neg;

        assign w_n   = 64'(r_m[l]) * 64'(gcd_pkg::PI_Q30)
                     + 64'((l < 2) ? gcd_pkg::BIAS_HALF : gcd_pkg::BIAS_LAT);
        assign w_p3  = 64'(r_nh[l][53:22]) * 64'(gcd_pkg::DIV_RECIP);
        assign w_p4  = 54'(r_qe[l]) * 54'(gcd_pkg::DIV_C);
        assign w_rem = r_nlo[l] - w_p4[25:0];
        assign w_cnt = 32'(r_rem[l] >= 26'(gcd_pkg::DIV_C))
                     + 32'(r_rem[l] >= 26'(2 * gcd_pkg::DIV_C))
                     + 32'(r_rem[l] >= 26'(3 * gcd_pkg::DIV_C))
                     + 32'(r_rem[l] >= 26'(4 * gcd_pkg::DIV_C));
        assign w_m1  = (33'(r_q[l]) > gcd_pkg::PI_Q30)
                     ? 32'(gcd_pkg::TWO_PI_Q30 - 34'(r_q[l])) : r_q[l];
        assign w_neg = w_m1 > gcd_pkg::HALF_PI_Q30;

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_m[l]   <= n_m[l];
                r_nh[l]  <= (l < 2) ? w_n[63:10] : 54'(w_n[63:9]);
                r_qe[l]  <= w_p3[62:31];
                r_nlo[l] <= r_nh[l][25:0];
                r_qe2[l] <= r_qe[l];
                r_rem[l] <= w_rem;
                r_q[l]   <= r_qe2[l] + w_cnt;
                r_z0[l]  <= w_neg ? 32'(gcd_pkg::PI_Q30 - 33'(w_m1)) : w_m1;
            end
        end

        if (l >= 2) begin : g_neg
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_fneg[l-2] <= w_neg;
                end
            end
        end
    end

    // sin/cos cordics
    logic signed [CW-1:0] w_cx [NL];
    logic signed [CW-1:0] w_cy [NL];

    for (genvar l = 0; l < NL; l++) begin : g_rot
        gcd_cordic #(
            .ITER      (ITER),
            .VECTORING (1'b0)
        ) u_rot (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_x   (gcd_pkg::CORDIC_GAIN),
            .i_y   ('0),
            .i_z   ({2'b00, r_z0[l]}),
            .o_x   (w_cx[l]),
            .o_y   (w_cy[l]),
            .o_z   ()
        );
    end

    logic [1:0] r_negd [ITER];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_negd[0] <= r_fneg;
            for (int k = 1; k < ITER; k++) begin
                r_negd[k] <= r_negd[k-1];
            end
        end
    end

    // haversine term
    logic signed [CW-1:0]   w_c1, w_c2;
    logic signed [2*CW-1:0] w_psh, w_psl, w_pcc, w_pt;
    logic signed [CW-1:0]   r_ash, r_slsq, r_cc, r_ash2, r_t;
    logic signed [CW:0]     w_sum;
    logic [30:0]            w_a;
    logic [30:0]            r_a, r_b;

    assign w_c1  = r_negd[ITER-1][0] ? -w_cx[2] : w_cx[2];
    assign w_c2  = r_negd[ITER-1][1] ? -w_cx[3] : w_cx[3];
    assign w_psh = w_cy[0] * w_cy[0];
    assign w_psl = w_cy[1] * w_cy[1];
    assign w_pcc = w_c1 * w_c2;
    assign w_pt  = r_cc * r_slsq;
    assign w_sum = {r_ash2[CW-1], r_ash2} + {r_t[CW-1], r_t};

    always_comb begin
        if (w_sum[CW]) begin
            w_a = '0;
        end else if (w_sum > (CW+1)'(gcd_pkg::ONE_Q30)) begin
            w_a = gcd_pkg::ONE_Q30;
        end else begin
            w_a = w_sum[30:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ash  <= w_psh[CW+29:30];
            r_slsq <= w_psl[CW+29:30];
            r_cc   <= w_pcc[CW+29:30];
            r_ash2 <= r_ash;
            r_t    <= w_pt[CW+29:30];
            r_a    <= w_a;
            r_b    <= gcd_pkg::ONE_Q30 - w_a;
        end
    end

    // square roots
    logic [SQS-1:0] w_ra, w_rb;

    gcd_isqrt u_sqrt_a (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_val  ({r_a, 30'd0}),
        .o_root (w_ra)
    );

    gcd_isqrt u_sqrt_b (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_val  ({r_b, 30'd0}),
        .o_root (w_rb)
    );

    // atan2
    logic signed [CW-1:0] w_az;

    gcd_cordic #(
        .ITER      (ITER),
        .VECTORING (1'b1)
    ) u_atan (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_x   ({(CW-SQS)'(0), w_rb}),
        .i_y   ({(CW-SQS)'(0), w_ra}),
        .i_z   ('0),
        .o_x   (),
        .o_y   (),
        .o_z   (w_az)
    );

    // radius scaling and saturation
    logic [32:0] w_ang;
    logic [63:0] r_pd;
    logic [64:0] w_rnd;
    logic [34:0] w_dist;
    logic        w_sat;
    logic [32:0] r_dist;
    logic        r_sat;

    assign w_ang  = w_az[CW-1] ? '0 : {w_az[31:0], 1'b0};
    assign w_rnd  = 65'(r_pd) + (65'd1 << 29);
    assign w_dist = w_rnd[64:30];
    assign w_sat  = w_dist > 35'(gcd_pkg::DIST_MAX);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pd   <= 64'(r_radius100) * 64'(w_ang);
            r_dist <= w_sat ? gcd_pkg::DIST_MAX : w_dist[32:0];
            r_sat  <= w_sat;
        end
    end

    assign o_distance_cm = r_dist;
    assign o_saturated   = r_sat;

endmodule

`default_nettype wire

[rtl/gcd_cordic.sv]
// ----------------------------------------------------------------------------
// gcd_cordic
// pipelined cordic, one iteration per stage, rotation or vectoring mode
// ----------------------------------------------------------------------------
`default_nettype none

module gcd_cordic #(
    parameter int ITER      = gcd_pkg::CORDIC_ITERATIONS,
    parameter bit VECTORING = 1'b0
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_en,
    input  wire logic signed [gcd_pkg::CW-1:0]  i_x,
    input  wire logic signed [gcd_pkg::CW-1:0]  i_y,
    input  wire logic signed [gcd_pkg::CW-1:0]  i_z,
    output logic signed      [gcd_pkg::CW-1:0]  o_x,
    output logic signed      [gcd_pkg::CW-1:0]  o_y,
    output logic signed      [gcd_pkg::CW-1:0]  o_z
);

    localparam int CW = gcd_pkg::CW;

    logic signed [CW-1:0] r_x [ITER];
    logic signed [CW-1:0] r_y [ITER];
    logic signed [CW-1:0] r_z [ITER];

    for (genvar k = 0; k < ITER; k++) begin : g_stage
        logic signed [CW-1:0] s_x, s_y, s_z, dx, dy, at;
        logic                 dir;

        if (k == 0) begin : g_first
            assign s_x = i_x;
            assign s_y = i_y;
            assign s_z = i_z;
        end else begin : g_next
            assign s_x = r_x[k-1];
            assign s_y = r_y[k-1];
            assign s_z = r_z[k-1];
        end

        assign dx  = s_y >>> k;
        assign dy  = s_x >>> k;
        assign at  = gcd_pkg::atan_step(k);
        // dir high: x -= dx, y += dy, z -= at
        assign dir = VECTORING ? (s_y[CW-1] | (s_y == '0)) : ~s_z[CW-1];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k] <= dir ? s_x - dx : s_x + dx;
                r_y[k] <= dir ? s_y + dy : s_y - dy;
                r_z[k] <= dir ? s_z - at : s_z + at;
            end
        end
    end

    assign o_x = r_x[ITER-1];
    assign o_y = r_y[ITER-1];
    assign o_z = r_z[ITER-1];

endmodule

`default_nettype wire

[rtl/gcd_isqrt.sv]
// ----------------------------------------------------------------------------
// gcd_isqrt
// pipelined bit-serial integer square root, one result bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module gcd_isqrt (
    input  wire logic                           i_clk,
    input  wire logic                           i_en,
    input  wire logic [gcd_pkg::SQ_IN_W-1:0]    i_val,
    output logic      [gcd_pkg::SQ_STEPS-1:0]   o_root
);

    localparam int STEPS = gcd_pkg::SQ_STEPS;
    localparam int SW    = gcd_pkg::SQ_W;

    logic [SW-1:0] r_v   [STEPS];
    logic [SW-1:0] r_res [STEPS];

    for (genvar k = 0; k < STEPS; k++) begin : g_stage
        logic [SW-1:0] s_v, s_res, one, sum;

        if (k == 0) begin : g_first
            assign s_v   = SW'(i_val);
            assign s_res = '0;
        end else begin : g_next
            assign s_v   = r_v[k-1];
            assign s_res = r_res[k-1];
        end

        assign one = SW'(1) << (2 * (STEPS - 1 - k));
        assign sum = s_res + one;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (s_v >= sum) begin
                    r_v[k]   <= s_v - sum;
                    r_res[k] <= (s_res >> 1) + one;
                end else begin
                    r_v[k]   <= s_v;
                    r_res[k] <= s_res >> 1;
                end
            end
        end
    end

    assign o_root = r_res[STEPS-1][STEPS-1:0];

endmodule

`default_nettype wire
